>>> src/pres80_pkg.sv
// pres80_pkg: shared types, constants and functions for the PRESENT-80 encryption pipeline
`default_nettype none

package pres80_pkg;

	localparam int unsigned BLOCK_W = 64;
	localparam int unsigned KEY_W   = 80;
	localparam int unsigned RKEY_W  = 64;
	localparam int unsigned CNT_W   = 5;

	// data handed from one round cell to the next
	typedef struct packed {
		logic                   valid;
		logic [BLOCK_W-1:0]     state;
		logic [KEY_W-1:0]       key;
	} pres_beat_t;

	// 4-bit s-box
	function automatic logic [3:0] sbox(input logic [3:0] nib);
		logic [3:0] r;
		case (nib)
			4'h0: r = 4'hC;
			4'h1: r = 4'h5;
			4'h2: r = 4'h6;
			4'h3: r = 4'hB;
			4'h4: r = 4'h9;
			4'h5: r = 4'h0;
			4'h6: r = 4'hA;
			4'h7: r = 4'hD;
			4'h8: r = 4'h3;
			4'h9: r = 4'hE;
			4'hA: r = 4'hF;
			4'hB: r = 4'h8;
			4'hC: r = 4'h4;
			4'hD: r = 4'h7;
			4'hE: r = 4'h1;
			default: r = 4'h2;
		endcase
		return r;
	endfunction

	// s-box over all sixteen nibbles
	function automatic logic [BLOCK_W-1:0] sub_layer(input logic [BLOCK_W-1:0] s);
		logic [BLOCK_W-1:0] r;
		r = '0;
		for (int n = 0; n < BLOCK_W / 4; n++) begin
			r[4*n +: 4] = sbox(s[4*n +: 4]);
		end
		return r;
	endfunction

	// bit i moves to 16*i mod 63, bit 63 stays
	function automatic logic [BLOCK_W-1:0] perm_layer(input logic [BLOCK_W-1:0] s);
		logic [BLOCK_W-1:0] r;
		r = '0;
		for (int i = 0; i < BLOCK_W - 1; i++) begin
			r[(16 * i) % (BLOCK_W - 1)] = s[i];
		end
		r[BLOCK_W-1] = s[BLOCK_W-1];
		return r;
	endfunction

	// round key is the top 64 bits of the key register
	function automatic logic [RKEY_W-1:0] subkey(input logic [KEY_W-1:0] k);
		return k[KEY_W-1 -: RKEY_W];
	endfunction

	// key register update: rotate left 61, s-box top nibble, add round counter
	function automatic logic [KEY_W-1:0] key_update(input logic [KEY_W-1:0] k,
							input logic [CNT_W-1:0] cnt);
		logic [KEY_W-1:0] r;
		r = {k[18:0], k[KEY_W-1:19]};
		r[KEY_W-1 -: 4] = sbox(r[KEY_W-1 -: 4]);
		r[19:15] = r[19:15] ^ cnt;
		return r;
	endfunction

endpackage

`default_nettype wire

>>> src/pres80_round_cell.sv
// pres80_round_cell: one registered PRESENT round with its key schedule step
`default_nettype none

module pres80_round_cell #(
	parameter int unsigned ROUND_IDX = 1
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  pres80_pkg::pres_beat_t   beat_in,
	output pres80_pkg::pres_beat_t   beat_out
);

	localparam logic [pres80_pkg::CNT_W-1:0] RoundCnt = pres80_pkg::CNT_W'(ROUND_IDX);

	logic                               valid_s1;
	logic [pres80_pkg::BLOCK_W-1:0]     state_s1;
	logic [pres80_pkg::KEY_W-1:0]       key_s1;
	logic [pres80_pkg::BLOCK_W-1:0]     state_next;
	logic [pres80_pkg::KEY_W-1:0]       key_next;

	// add round key, s-box layer, bit permutation
	always_comb begin
		state_next = pres80_pkg::perm_layer(pres80_pkg::sub_layer(
			beat_in.state ^ pres80_pkg::subkey(beat_in.key)));
		key_next = pres80_pkg::key_update(beat_in.key, RoundCnt);
	end

	// beat valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= beat_in.valid;
		end
	end

	// payload moves every cycle
	always_ff @(posedge clk) begin
		state_s1 <= state_next;
		key_s1   <= key_next;
	end

	assign beat_out.valid = valid_s1;
	assign beat_out.state = state_s1;
	assign beat_out.key   = key_s1;

endmodule

`default_nettype wire

>>> src/present80_block_encrypt.sv
// present80_block_encrypt: PRESENT-80 encryption as a chain of pipelined round cells
//
//  channel  | handshake       | payload
//  ---------+-----------------+-----------------------------------
//  input    | start / busy    | plaintext[63:0], key_high[15:0], key_low[63:0]
//  result   | done (strobe)   | ciphertext[63:0]
//
// one block per clock; from accept to done each block passes through the register of each round cell
// in turn and then through the final whitening register.
// busy is always low: the cell chain advances every cycle and never holds a beat.
// arst_n clears the valid flags of all cells and the result strobe.
// the receiver cannot stall; a result beat is on the ports for exactly one cycle.
`default_nettype none

module present80_block_encrypt #(
	parameter int unsigned ROUND_COUNT = 31
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [63:0] plaintext,
	input  wire  [15:0] key_high,
	input  wire  [63:0] key_low,
	output logic        done,
	output logic [63:0] ciphertext
);

	pres80_pkg::pres_beat_t chain [ROUND_COUNT+1];

	logic        done_q;
	logic [63:0] ciphertext_q;

	assign busy = 1'b0;

	// head of the chain
	assign chain[0].valid = start;
	assign chain[0].state = plaintext;
	assign chain[0].key   = {key_high, key_low};

	// one cell per round
	for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
		pres80_round_cell #(
			.ROUND_IDX(r + 1)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.beat_in (chain[r]),
			.beat_out(chain[r+1])
		);
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= chain[ROUND_COUNT].valid;
		end
	end

	// final whitening
	always_ff @(posedge clk) begin
		ciphertext_q <= chain[ROUND_COUNT].state ^
			pres80_pkg::subkey(chain[ROUND_COUNT].key);
	end

	assign done       = done_q;
	assign ciphertext = ciphertext_q;

endmodule

`default_nettype wire
